@@ sv/sab_pkg.sv @@
// Shared types, constants and helpers for the slot allocator bitmap core.
// No dependencies; every other file of the block refers to this package.
package sab_pkg;

    // Built slot count and derived widths
    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int BYTES_W = 13;
    localparam int OFF_W   = 19;
    localparam int PROD_W  = SLOT_W + BYTES_W;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [OFF_W-1:0]   OFF_MAX       = '1;
    localparam logic [CNT_W-1:0]   CAP_RESET     = CNT_W'(SLOTS);
    localparam logic [BYTES_W-1:0] BYTES_RESET   = BYTES_W'(1);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_FIRST = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND_NEXT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0]  slot;
        logic [OFF_W-1:0]  byte_offset;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  occupied_count;
    } t_rsp;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_find;

    // Lowest set bit of a slot vector
    function automatic t_find lowest_set(input logic [SLOTS-1:0] v);
        t_find r;
        r.found = |v;
        r.idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.idx = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ sv/sab_if.sv @@
// Handshake channel interfaces for the slot allocator: request, response, config.
// Depends on sab_pkg for field widths.
interface sab_req_if;
    logic                            valid;
    logic                            ready;
    logic [sab_pkg::KIND_W-1:0]      kind;
    logic [sab_pkg::SLOT_W-1:0]      index;

    modport source (output valid, kind, index, input ready);
    modport sink   (input valid, kind, index, output ready);
endinterface

interface sab_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sab_pkg::CNT_W-1:0]       slot;
    logic [sab_pkg::OFF_W-1:0]       byte_offset;
    logic [sab_pkg::STAT_W-1:0]      status;
    logic [sab_pkg::CNT_W-1:0]       occupied_count;

    modport source (output valid, slot, byte_offset, status, occupied_count, input ready);
    modport sink   (input valid, slot, byte_offset, status, occupied_count, output ready);
endinterface

interface sab_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sab_pkg::CFG_IDX_W-1:0]   index;
    logic [sab_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/slot_allocator_bitmap_core.sv @@
// Top level of the bitmap first-fit slot allocator.
// Depends on sab_pkg, the channel interfaces in sab_if.sv and sab_ops.
//
// Slot allocator over a 64-slot occupancy bitmap, all free after reset.
// Requests: allocate (lowest free slot below capacity, with its byte offset
// slot * slot_bytes), free, find first occupied, find next occupied after an
// index, and clear all. Every response also carries the occupied count over
// all slots. Each request is held in an input register and evaluated against
// the bitmap combinationally; the result loads the output register when that
// register is empty or drains. One request is taken every cycle unless the
// output stalls. The bitmap and count update at the same edge that loads the
// response, so back-to-back requests always see each other's effect. The
// output register holds under backpressure and stalls the input stage only
// when both are full. Capacity writes keep the low 7 data bits, and values
// above 64 are then clamped to 64 when stored; configuration writes are
// always accepted and should be made only while no request is in flight.

module slot_allocator_bitmap_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sab_req_if.sink       i_req,
    sab_rsp_if.source     o_rsp,
    sab_cfg_if.sink       i_cfg
);

    // Configuration registers
    logic [sab_pkg::CNT_W-1:0]   r_cap;
    logic [sab_pkg::BYTES_W-1:0] r_slot_bytes;

    // Input stage
    logic                        r_s1_valid;
    logic [sab_pkg::KIND_W-1:0]  r_s1_kind;
    logic [sab_pkg::SLOT_W-1:0]  r_s1_index;

    // Allocator state
    logic [sab_pkg::SLOTS-1:0]   r_bits;
    logic [sab_pkg::CNT_W-1:0]   r_count;
    logic [sab_pkg::SLOTS-1:0]   n_bits;
    logic [sab_pkg::CNT_W-1:0]   n_count;

    // Output stage
    logic                        r_out_valid;
    sab_pkg::t_rsp               r_out;
    sab_pkg::t_rsp               n_out;

    logic                        s1_adv;
    logic                        req_acc;
    logic [sab_pkg::CNT_W-1:0]   cap_wr;

    // Advance the input stage when the output register is empty or drains
    assign s1_adv  = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign req_acc = i_req.valid && i_req.ready;

    assign i_cfg.ready = 1'b1;

    // Clamp capacity to the built slot count on write
    assign cap_wr = (i_cfg.data[sab_pkg::CNT_W-1:0] > sab_pkg::CNT_W'(sab_pkg::SLOTS))
                  ? sab_pkg::CNT_W'(sab_pkg::SLOTS) : i_cfg.data[sab_pkg::CNT_W-1:0];

    sab_ops u_ops (
        .i_bits       (r_bits),
        .i_count      (r_count),
        .i_cap        (r_cap),
        .i_slot_bytes (r_slot_bytes),
        .i_kind       (r_s1_kind),
        .i_index      (r_s1_index),
        .o_bits       (n_bits),
        .o_count      (n_count),
        .o_rsp        (n_out)
    );

    // Control state, configuration and bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= sab_pkg::CAP_RESET;
            r_slot_bytes <= sab_pkg::BYTES_RESET;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bits       <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    sab_pkg::REG_CAPACITY:   r_cap        <= cap_wr;
                    sab_pkg::REG_SLOT_BYTES: r_slot_bytes <= i_cfg.data[sab_pkg::BYTES_W-1:0];
                    default: begin
                        r_cap <= r_cap;
                    end
                endcase
            end
            if (req_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_bits      <= n_bits;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept / advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1_kind  <= i_req.kind;
            r_s1_index <= i_req.index;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.slot           = r_out.slot;
    assign o_rsp.byte_offset    = r_out.byte_offset;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.occupied_count = r_out.occupied_count;

endmodule

@@ sv/sab_ops.sv @@
// Combinational request evaluation: search, offset, bitmap and count update.
// Depends on sab_pkg.
module sab_ops (
    input  logic [sab_pkg::SLOTS-1:0]   i_bits,
    input  logic [sab_pkg::CNT_W-1:0]   i_count,
    input  logic [sab_pkg::CNT_W-1:0]   i_cap,
    input  logic [sab_pkg::BYTES_W-1:0] i_slot_bytes,
    input  logic [sab_pkg::KIND_W-1:0]  i_kind,
    input  logic [sab_pkg::SLOT_W-1:0]  i_index,
    output logic [sab_pkg::SLOTS-1:0]   o_bits,
    output logic [sab_pkg::CNT_W-1:0]   o_count,
    output sab_pkg::t_rsp               o_rsp
);

    logic [sab_pkg::SLOTS-1:0]  cap_mask;
    logic [sab_pkg::SLOTS-1:0]  from_mask;
    logic [sab_pkg::CNT_W-1:0]  from;
    sab_pkg::t_find             free_hit;
    sab_pkg::t_find             occ_hit;
    logic [sab_pkg::SLOT_W-1:0] sel_idx;
    logic [sab_pkg::PROD_W-1:0] prod;
    logic [sab_pkg::OFF_W-1:0]  offset;

    assign from = (i_kind == sab_pkg::KIND_FIND_FIRST) ? '0
                : {1'b0, i_index} + sab_pkg::CNT_W'(1);

    always_comb begin
        for (int i = 0; i < sab_pkg::SLOTS; i++) begin
            cap_mask[i]  = sab_pkg::CNT_W'(i) < i_cap;
            from_mask[i] = sab_pkg::CNT_W'(i) >= from;
        end
    end

    assign free_hit = sab_pkg::lowest_set(~i_bits & cap_mask);
    assign occ_hit  = sab_pkg::lowest_set(i_bits & cap_mask & from_mask);

    assign sel_idx = (i_kind == sab_pkg::KIND_ALLOC) ? free_hit.idx : occ_hit.idx;
    assign prod    = sab_pkg::PROD_W'(sel_idx) * sab_pkg::PROD_W'(i_slot_bytes);
    // Saturate only matters if the slot or size range ever grows
    assign offset  = (prod > sab_pkg::PROD_W'(sab_pkg::OFF_MAX)) ? sab_pkg::OFF_MAX
                   : sab_pkg::OFF_W'(prod);

    always_comb begin
        o_bits  = i_bits;
        o_count = i_count;
        o_rsp   = '0;
        case (i_kind)
            sab_pkg::KIND_ALLOC: begin
                if (free_hit.found) begin
                    o_rsp.slot           = {1'b0, free_hit.idx};
                    o_rsp.byte_offset    = offset;
                    o_bits[free_hit.idx] = 1'b1;
                    o_count              = i_count + sab_pkg::CNT_W'(1);
                end else begin
                    o_rsp.slot   = i_cap;
                    o_rsp.status = sab_pkg::STAT_FULL;
                end
            end
            sab_pkg::KIND_FREE: begin
                if ({1'b0, i_index} >= i_cap) begin
                    o_rsp.status = sab_pkg::STAT_RANGE;
                end else begin
                    o_bits[i_index] = 1'b0;
                    if (i_bits[i_index]) begin
                        o_count = i_count - sab_pkg::CNT_W'(1);
                    end
                end
            end
            sab_pkg::KIND_FIND_FIRST, sab_pkg::KIND_FIND_NEXT: begin
                if (occ_hit.found) begin
                    o_rsp.slot        = {1'b0, occ_hit.idx};
                    o_rsp.byte_offset = offset;
                end else begin
                    o_rsp.slot = i_cap;
                end
            end
            sab_pkg::KIND_CLEAR: begin
                o_bits  = '0;
                o_count = '0;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
        o_rsp.occupied_count = o_count;
    end

endmodule

@@ sv/sab_checker.sv @@
// Port-level assertions for the slot allocator core, attached by bind.
// Depends on sab_pkg and slot_allocator_bitmap_core.
module sab_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [sab_pkg::CNT_W-1:0]    i_slot,
    input logic [sab_pkg::OFF_W-1:0]    i_byte_offset,
    input logic [sab_pkg::STAT_W-1:0]   i_status,
    input logic [sab_pkg::CNT_W-1:0]    i_occupied_count
);

    logic rsp_acc;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // Drop any response held across reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // Hold a stalled response
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_slot)
            && $stable(i_byte_offset) && $stable(i_status) && $stable(i_occupied_count))
        else $error("stalled response changed");

    // Full and out-of-range results carry no offset
    a_err_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == sab_pkg::STAT_FULL || i_status == sab_pkg::STAT_RANGE)
            |-> i_byte_offset == '0)
        else $error("error response with nonzero offset");

    // No undefined status code ever shows
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == sab_pkg::STAT_OK || i_status == sab_pkg::STAT_FULL
            || i_status == sab_pkg::STAT_RANGE))
        else $error("undefined status code");

    // Consecutive responses grow the count by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_acc ##1 rsp_acc |-> {1'b0, i_occupied_count}
            <= {1'b0, $past(i_occupied_count)} + (sab_pkg::CNT_W + 1)'(1))
        else $error("occupied count jumped by more than one");

endmodule

bind slot_allocator_bitmap_core sab_checker u_sab_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_slot           (o_rsp.slot),
    .i_byte_offset    (o_rsp.byte_offset),
    .i_status         (o_rsp.status),
    .i_occupied_count (o_rsp.occupied_count)
);
